@@ hw/rtl/fqcf_pkg.sv @@
// Shared types, constants and codes of the Q15 circular-buffer FIR filter.
`timescale 1ns / 1ps

package fqcf_pkg;

   // Default number of taps.
   localparam int TAPS_DEFAULT = 21;

   // Fixed widths of the item fields.
   localparam int DATA_W = 16;
   localparam int IDX_W  = 5;

   // Width of the stored product: bit 31 of the full product is lost by the doubling.
   localparam int PROD_W = 2 * DATA_W - 1;

   // Rounding constant added before the arithmetic shift, and the shift itself.
   localparam logic [2*DATA_W-1:0] ROUND_CONST = 32'h0000_8000;
   localparam int                  TERM_SHIFT  = 16;

   // Action codes of an input item.
   localparam logic ACT_FILTER = 1'b0;
   localparam logic ACT_LOAD   = 1'b1;

   // Sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_RUN,
      ST_DRAIN
   } state_type;

   // Control from the sequencer to the multiply-accumulate unit.
   typedef struct packed {
      logic clear;        // start a new sum
      logic issue_valid;  // a tap read is issued this cycle
      logic issue_last;   // the issued read is the final tap
      logic out_free;     // the output register can take a result
   } mac_ctrl_type;

   // Status from the multiply-accumulate unit to the sequencer.
   typedef struct packed {
      logic done;         // the final term is ready and the sum is complete
   } mac_status_type;

endpackage

@@ hw/rtl/fqcf_store.sv @@
// Single-port-write, registered-read memory with per-entry valid bits that read as zero.
`timescale 1ns / 1ps

module fqcf_store #(
   parameter int DEPTH  = fqcf_pkg::TAPS_DEFAULT,
   parameter int ADDR_W = 5,
   parameter int DATA_W = fqcf_pkg::DATA_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DEPTH-1:0]  valid_ff;
   logic [DEPTH-1:0]  valid_in;
   logic [DATA_W-1:0] rd_data_ff;
   logic [DATA_W-1:0] rd_data_in;

   // Storage array, written on the clock edge.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // An entry becomes valid when first written; reset returns every entry to zero.
   always_comb begin
      valid_in = valid_ff;
      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Registered read; an entry never written reads as zero.
   always_comb begin
      rd_data_in = rd_data_ff;
      if (rd_en) begin
         rd_data_in = valid_ff[rd_addr] ? mem_ff[rd_addr] : '0;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= rd_data_in;
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/fqcf_mac.sv @@
// Multiply-accumulate unit: registered Q15 product, rounding shift and wrapping sum.
`timescale 1ns / 1ps

module fqcf_mac (
   input  logic                          clock,
   input  logic                          reset,
   input  fqcf_pkg::mac_ctrl_type        ctrl,
   input  logic [fqcf_pkg::DATA_W-1:0]   coef,
   input  logic [fqcf_pkg::DATA_W-1:0]   sample,
   output fqcf_pkg::mac_status_type      status,
   output logic [fqcf_pkg::DATA_W-1:0]   filtered
);

   localparam int DW = fqcf_pkg::DATA_W;
   localparam int PW = fqcf_pkg::PROD_W;

   // Read stage: marks that the memory outputs hold a coefficient and sample pair.
   logic rd_vld_ff, rd_vld_in;
   logic rd_last_ff, rd_last_in;

   // Product stage.
   logic          prod_vld_ff, prod_vld_in;
   logic          prod_last_ff, prod_last_in;
   logic [PW-1:0] prod_ff, prod_in;

   // Accumulator: only the low half of the wrapping sum reaches the output.
   logic [DW-1:0] acc_ff, acc_in;

   logic signed [2*DW-1:0] prod_full;
   logic        [2*DW-1:0] rounded;
   logic        [DW-1:0]   term;
   logic                   hold;

   // The final term waits in the product stage while the output register is full.
   assign hold = prod_vld_ff & prod_last_ff & ~ctrl.out_free;

   assign prod_full = $signed(coef) * $signed(sample);

   // Term is ((2*c*x + 0x8000) >>> 16); its low half is the rounded high half of 2*c*x.
   assign rounded = {prod_ff, 1'b0} + fqcf_pkg::ROUND_CONST;
   assign term    = rounded[fqcf_pkg::TERM_SHIFT +: DW];

   // Pipeline valid flags and data.
   always_comb begin
      rd_vld_in    = ctrl.issue_valid;
      rd_last_in   = ctrl.issue_last;
      prod_vld_in  = prod_vld_ff;
      prod_last_in = prod_last_ff;
      prod_in      = prod_ff;
      if (!hold) begin
         prod_vld_in  = rd_vld_ff;
         prod_last_in = rd_last_ff;
         if (rd_vld_ff) begin
            prod_in = prod_full[PW-1:0];
         end
      end
   end

   // Sum every term but the final one, which is added on the way to the output.
   always_comb begin
      acc_in = acc_ff;
      if (ctrl.clear) begin
         acc_in = '0;
      end else if (prod_vld_ff && !prod_last_ff) begin
         acc_in = acc_ff + term;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         rd_last_ff   <= 1'b0;
         prod_vld_ff  <= 1'b0;
         prod_last_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= rd_vld_in;
         rd_last_ff   <= rd_last_in;
         prod_vld_ff  <= prod_vld_in;
         prod_last_ff <= prod_last_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign status.done = prod_vld_ff & prod_last_ff;
   assign filtered    = acc_ff + term;

endmodule

@@ hw/rtl/fir_q15_circular_filter.sv @@
// Top level of the Q15 FIR filter: sequencer, delay-line and coefficient memories, MAC.
`timescale 1ns / 1ps

// A filter item (action 0) writes its sample into the circular delay line and then
// streams TAPS coefficient and sample pairs out of two registered-read memories
// into a single multiplier, one tap per cycle, from the oldest sample to the newest.
// A filter item holds the block from its transfer until its final sum enters the
// output register; in between lie the multiply-accumulate per tap and the memory
// read and product registers in front of the sum. The block is held longer while
// the previous result still waits in a stalled output register, since the final sum
// cannot enter it until then. A load item (action 1) writes one coefficient in the
// cycle of its transfer and leaves the block ready for the next item; a load whose
// index is TAPS or more is dropped. Only filter items give a result. The
// result sits in an output register, so the next item is taken while a finished
// result still waits on rsp_stall. After reset all samples and coefficients read as
// zero, with no clearing pass.
module fir_q15_circular_filter #(
   parameter int TAPS = fqcf_pkg::TAPS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_action,
   input  logic signed [fqcf_pkg::DATA_W-1:0]  req_sample,
   input  logic        [fqcf_pkg::IDX_W-1:0]   req_coef_index,
   input  logic signed [fqcf_pkg::DATA_W-1:0]  req_coef_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [fqcf_pkg::DATA_W-1:0]  rsp_filtered
);

   localparam int DW     = fqcf_pkg::DATA_W;
   localparam int ADDR_W = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam logic [ADDR_W-1:0] LAST_TAP = ADDR_W'(TAPS - 1);

   fqcf_pkg::state_type      state_ff, state_in;
   fqcf_pkg::mac_ctrl_type   mac_ctrl;
   fqcf_pkg::mac_status_type mac_status;

   logic [ADDR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ADDR_W-1:0] rd_pos_ff, rd_pos_in;
   logic [ADDR_W-1:0] tap_cnt_ff, tap_cnt_in;
   logic [ADDR_W-1:0] wr_ptr_next;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [DW-1:0] rsp_filtered_ff, rsp_filtered_in;

   logic          req_xfer, sample_xfer, load_xfer, coef_ok;
   logic          issue_valid, issue_last, tap_last;
   logic          out_free, final_xfer;
   logic [DW-1:0] coef_rd, sample_rd, mac_filtered;

   // Transfer decode.
   assign req_xfer    = req_valid & ~req_stall;
   assign sample_xfer = req_xfer & (req_action == fqcf_pkg::ACT_FILTER);
   assign load_xfer   = req_xfer & (req_action == fqcf_pkg::ACT_LOAD);
   assign coef_ok     = (32'(req_coef_index) < TAPS);

   assign tap_last    = (tap_cnt_ff == LAST_TAP);
   assign wr_ptr_next = (wr_ptr_ff == LAST_TAP) ? '0 : wr_ptr_ff + 1'b1;

   // The output register is free when empty or when its result transfers now.
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign final_xfer = mac_status.done & out_free;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         fqcf_pkg::ST_IDLE: begin
            if (sample_xfer) begin
               state_in = fqcf_pkg::ST_RUN;
            end
         end
         fqcf_pkg::ST_RUN: begin
            if (tap_last) begin
               state_in = fqcf_pkg::ST_DRAIN;
            end
         end
         fqcf_pkg::ST_DRAIN: begin
            if (final_xfer) begin
               state_in = fqcf_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = fqcf_pkg::ST_IDLE;
         end
      endcase
   end

   // State outputs.
   always_comb begin
      req_stall   = 1'b1;
      issue_valid = 1'b0;
      issue_last  = 1'b0;
      unique case (state_ff)
         fqcf_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         fqcf_pkg::ST_RUN: begin
            issue_valid = 1'b1;
            issue_last  = tap_last;
         end
         fqcf_pkg::ST_DRAIN: begin
            req_stall = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // Write pointer, read position and tap counter. Reads start the cycle after the
   // sample write, so the newest entry is never read and written at once.
   always_comb begin
      wr_ptr_in  = wr_ptr_ff;
      rd_pos_in  = rd_pos_ff;
      tap_cnt_in = tap_cnt_ff;
      if (sample_xfer) begin
         wr_ptr_in  = wr_ptr_next;
         rd_pos_in  = wr_ptr_next;
         tap_cnt_in = '0;
      end else if (issue_valid) begin
         rd_pos_in  = (rd_pos_ff == LAST_TAP) ? '0 : rd_pos_ff + 1'b1;
         tap_cnt_in = tap_last ? tap_cnt_ff : tap_cnt_ff + 1'b1;
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in    = rsp_valid_ff & rsp_stall;
      rsp_filtered_in = rsp_filtered_ff;
      if (final_xfer) begin
         rsp_valid_in    = 1'b1;
         rsp_filtered_in = mac_filtered;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= fqcf_pkg::ST_IDLE;
         wr_ptr_ff    <= '0;
         rd_pos_ff    <= '0;
         tap_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ptr_ff    <= wr_ptr_in;
         rd_pos_ff    <= rd_pos_in;
         tap_cnt_ff   <= tap_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_filtered_ff <= rsp_filtered_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_filtered = rsp_filtered_ff;

   // Circular delay line.
   fqcf_store #(
      .DEPTH  (TAPS),
      .ADDR_W (ADDR_W),
      .DATA_W (DW)
   ) u_history (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (sample_xfer),
      .wr_addr (wr_ptr_ff),
      .wr_data (req_sample),
      .rd_en   (issue_valid),
      .rd_addr (rd_pos_ff),
      .rd_data (sample_rd)
   );

   // Coefficient table.
   fqcf_store #(
      .DEPTH  (TAPS),
      .ADDR_W (ADDR_W),
      .DATA_W (DW)
   ) u_weights (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (load_xfer & coef_ok),
      .wr_addr (ADDR_W'(req_coef_index)),
      .wr_data (req_coef_value),
      .rd_en   (issue_valid),
      .rd_addr (tap_cnt_ff),
      .rd_data (coef_rd)
   );

   // Multiply-accumulate.
   assign mac_ctrl.clear       = sample_xfer;
   assign mac_ctrl.issue_valid = issue_valid;
   assign mac_ctrl.issue_last  = issue_last;
   assign mac_ctrl.out_free    = out_free;

   fqcf_mac u_mac (
      .clock    (clock),
      .reset    (reset),
      .ctrl     (mac_ctrl),
      .coef     (coef_rd),
      .sample   (sample_rd),
      .status   (mac_status),
      .filtered (mac_filtered)
   );

endmodule

@@ hw/rtl/fqcf_checker.sv @@
// Port-level checks of the FIR filter's sequencing, bound to the top level.
`timescale 1ns / 1ps

module fqcf_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_valid,
   input logic                               req_stall,
   input logic                               req_action,
   input logic signed [fqcf_pkg::DATA_W-1:0] rsp_filtered,
   input logic                               rsp_valid,
   input logic                               rsp_stall
);

   // Reset empties the output register.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_filtered))
      else $error("stalled result changed or dropped");

   // A sample transfer occupies the block in the following cycle.
   a_filter_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == fqcf_pkg::ACT_FILTER |=> req_stall)
      else $error("input taken during a filter pass");

   // A coefficient load leaves the block ready for the next item.
   a_load_ready: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_action == fqcf_pkg::ACT_LOAD |=> !req_stall)
      else $error("coefficient load stalled the input");

   // A new result only appears at the end of a filter pass.
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result without a filter pass");

endmodule

bind fir_q15_circular_filter fqcf_checker u_fqcf_checker (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_action   (req_action),
   .rsp_filtered (rsp_filtered),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall)
);

@@ dv/tb_fir_q15_circular_filter.sv @@
// Self-checking testbench of the Q15 circular-buffer FIR filter with a built-in predictor.
`timescale 1ns / 1ps

module tb_fir_q15_circular_filter;

   localparam int TAPS         = fqcf_pkg::TAPS_DEFAULT;
   localparam int DW           = fqcf_pkg::DATA_W;
   localparam int IW           = fqcf_pkg::IDX_W;
   localparam int RANDOM_ITEMS = 173;
   localparam int LIMIT_CYCLES = 400000;

   // One item of the input channel.
   typedef struct {
      logic                 action;
      logic signed [DW-1:0] sample;
      logic [IW-1:0]        coef_index;
      logic signed [DW-1:0] coef_value;
   } fir_item_type;

   logic                 clock          = 1'b0;
   logic                 reset          = 1'b1;
   logic                 req_valid      = 1'b0;
   logic                 req_stall;
   logic                 req_action     = fqcf_pkg::ACT_FILTER;
   logic signed [DW-1:0] req_sample     = '0;
   logic [IW-1:0]        req_coef_index = '0;
   logic signed [DW-1:0] req_coef_value = '0;
   logic                 rsp_valid;
   logic                 rsp_stall      = 1'b0;
   logic signed [DW-1:0] rsp_filtered;

   // Stimulus waiting to be driven, and filter outputs still owed by the block.
   fir_item_type         pending_items[$];
   logic signed [DW-1:0] filtered_due[$];
   fir_item_type         item_on_bus;

   // Private copy of the filter state.
   logic signed [DW-1:0] delay_line[TAPS];
   logic signed [DW-1:0] coef_table[TAPS];
   int                   newest_slot;

   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   int fail_count     = 0;
   int elapsed_cycles = 0;
   logic signed [DW-1:0] want_filtered;

   fir_q15_circular_filter #(
      .TAPS (TAPS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_sample     (req_sample),
      .req_coef_index (req_coef_index),
      .req_coef_value (req_coef_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_filtered   (rsp_filtered)
   );

   // Clock with a 4 ns period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Update the filter state for one accepted item and queue the output it owes.
   function automatic void filter_transfer(input fir_item_type it);
      logic signed [2*DW-1:0] product;
      logic [2*DW-1:0]        rounded;
      logic signed [2*DW-1:0] term;
      logic [2*DW-1:0]        acc;
      int                     slot;
      if (it.action == fqcf_pkg::ACT_LOAD) begin
         if (it.coef_index < TAPS)
            coef_table[it.coef_index] = it.coef_value;
         return;
      end
      delay_line[newest_slot] = it.sample;
      newest_slot = (newest_slot + 1 == TAPS) ? 0 : newest_slot + 1;
      // Walk from the oldest sample to the newest; the doubling may wrap to -2^31.
      acc  = '0;
      slot = newest_slot;
      for (int k = 0; k < TAPS; k++) begin
         product = coef_table[k] * delay_line[slot];
         rounded = (product << 1) + fqcf_pkg::ROUND_CONST;
         term    = $signed(rounded) >>> fqcf_pkg::TERM_SHIFT;
         acc     = acc + term;
         slot    = (slot + 1 == TAPS) ? 0 : slot + 1;
      end
      filtered_due.push_back(acc[DW-1:0]);
   endfunction

   // Q15 value with a bias toward the full-scale and zero corners.
   function automatic logic signed [DW-1:0] pick_q15();
      case ($urandom_range(9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return -16'sd1;
         3: return 16'sd0;
         default: return DW'($urandom);
      endcase
   endfunction

   task automatic queue_filter(input logic signed [DW-1:0] sample);
      fir_item_type it;
      it.action     = fqcf_pkg::ACT_FILTER;
      it.sample     = sample;
      it.coef_index = IW'($urandom);
      it.coef_value = DW'($urandom);
      pending_items.push_back(it);
   endtask

   task automatic queue_load(input logic [IW-1:0] idx, input logic signed [DW-1:0] value);
      fir_item_type it;
      it.action     = fqcf_pkg::ACT_LOAD;
      it.sample     = DW'($urandom);
      it.coef_index = idx;
      it.coef_value = value;
      pending_items.push_back(it);
   endtask

   // Random items: mostly filter samples, loads mostly in range, now and then a full table.
   task automatic queue_random(input int count);
      logic signed [DW-1:0] fill;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(99) == 0) begin
            fill = pick_q15();
            for (int k = 0; k < TAPS; k++)
               queue_load(IW'(k), fill);
         end else if ($urandom_range(99) < 65) begin
            queue_filter(pick_q15());
         end else if ($urandom_range(5) == 0) begin
            queue_load(IW'($urandom_range(31)), pick_q15());
         end else begin
            queue_load(IW'($urandom_range(TAPS - 1)), pick_q15());
         end
      end
   endtask

   // Hold the sender until every queued item is taken and every output has come back.
   // The check runs on the falling edge, after the driver has settled its outputs.
   task automatic drain_all();
      @(negedge clock);
      while (pending_items.size() != 0 || req_valid || filtered_due.size() != 0)
         @(negedge clock);
   endtask

   // Request driver: present the next pending item unless the sender idles.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            filter_transfer(item_on_bus);
         if (!req_valid || !req_stall) begin
            if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               item_on_bus     = pending_items.pop_front();
               req_action     <= item_on_bus.action;
               req_sample     <= item_on_bus.sample;
               req_coef_index <= item_on_bus.coef_index;
               req_coef_value <= item_on_bus.coef_value;
               req_valid      <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result channel back-pressure.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_stall_pct);
      end
   end

   // Result monitor: each transfer is checked against the oldest owed output.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (filtered_due.size() == 0) begin
            $error("unexpected result transfer: filtered actual %0d", rsp_filtered);
            fail_count++;
         end else begin
            want_filtered = filtered_due.pop_front();
            if (rsp_filtered !== want_filtered) begin
               $error("filtered mismatch: expected %0d, actual %0d", want_filtered,
                      rsp_filtered);
               fail_count++;
            end
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      elapsed_cycles++;
      if (elapsed_cycles >= LIMIT_CYCLES) begin
         $display("tb_fir_q15_circular_filter failed");
         $finish;
      end
   end

   // Test sequence: reset, directed corners, then random traffic under four idle patterns.
   initial begin
      for (int k = 0; k < TAPS; k++) begin
         delay_line[k] = '0;
         coef_table[k] = '0;
      end
      newest_slot = 0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // With the reset coefficients every output is zero.
      queue_filter(16'sh7FFF);
      queue_filter(16'sh8000);
      // Full-scale coefficient on the newest and the oldest tap.
      queue_load(IW'(TAPS - 1), 16'sh8000);
      queue_load(5'd0, 16'sh8000);
      // Out-of-range loads must leave the table alone.
      queue_load(IW'(TAPS), 16'sh7FFF);
      queue_load(5'd31, 16'sh7FFF);
      // Full-scale product of two negative extremes.
      queue_filter(16'sh8000);
      queue_filter(16'sh7FFF);
      queue_filter(16'sd0);
      queue_filter(-16'sd1);
      queue_filter(16'sd1);
      queue_load(5'd10, 16'sh7FFF);
      queue_load(5'd5, -16'sd1);
      queue_load(5'd1, 16'sd1);
      queue_filter(16'sh8000);
      queue_filter(16'sh8000);
      queue_filter(16'sh7FFF);
      queue_filter(16'sh5A5A);
      queue_filter(-16'sh5A5B);
      drain_all();

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 54; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 54; end
            default: begin send_idle_pct = 9; recv_stall_pct = 9; end
         endcase
         queue_random(RANDOM_ITEMS);
         drain_all();
      end

      repeat (TAPS + 8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_fir_q15_circular_filter passed");
      end else begin
         $display("tb_fir_q15_circular_filter failed");
      end
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/fqcf_pkg.sv
hw/rtl/fqcf_store.sv
hw/rtl/fqcf_mac.sv
hw/rtl/fir_q15_circular_filter.sv
hw/rtl/fqcf_checker.sv
dv/tb_fir_q15_circular_filter.sv
